// ===== rtl/core/nrtp_pkg.sv =====
// Shared constants, types and helper functions of the RMC time parser.
package nrtp_pkg;

  localparam int FIELD_LIMIT = 16;
  localparam int FCOUNT_W    = $clog2(FIELD_LIMIT + 1);
  localparam int NUM_DIGITS  = 6;
  localparam int DIG_W       = $clog2(NUM_DIGITS);
  localparam int REPORT_LEN  = 10;
  localparam int IDX_W       = $clog2(REPORT_LEN);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TALKER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 8'd1;

  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_G          = 8'h47;
  localparam logic [7:0] CH_R          = 8'h52;
  localparam logic [7:0] CH_M          = 8'h4D;
  localparam logic [7:0] CH_C          = 8'h43;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_X          = 8'h58;
  localparam logic [7:0] CH_Y          = 8'h59;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] HEX_ALPHA_ADJ = 8'h37;
  localparam logic [7:0] TALKER_RESET  = 8'h50;
  localparam logic [7:0] HOUR_HALF     = 8'd12;

  typedef logic [3:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digits_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_G,
    ST_HDR_TALK,
    ST_HDR_R,
    ST_HDR_M,
    ST_HDR_C,
    ST_HDR_COMMA,
    ST_TIME,
    ST_VALID,
    ST_WAIT_STAR,
    ST_HIGH_HEX,
    ST_LOW_HEX
  } step_t;

  // One finished report handed from the parser to the queue.
  typedef struct packed {
    logic    valid;
    digits_t digits;
  } report_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstatus_t;

  // Hex digit to nibble; letters are moved down by 0x37 and any byte gives some nibble.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] a;
    a = (c > CH_NINE) ? (c - HEX_ALPHA_ADJ) : c;
    return a[3:0];
  endfunction

  // UTC hour to local 12-hour form, worked on the raw nibbles without range checks.
  function automatic digits_t convert_hour(input digits_t d, input logic [3:0] off);
    logic [7:0] h;
    logic [8:0] s;
    digits_t    r;
    h = 8'({d[0], 3'b000}) + 8'({d[0], 1'b0}) + 8'(d[1]);
    r = d;
    if (h > HOUR_HALF) h = h - HOUR_HALF;
    if (h <= {4'b0000, off}) h = h + HOUR_HALF;
    s = {1'b0, h} - {5'b00000, off};
    // A negative result wraps to a huge value and so counts as above nine.
    if (s[8] || (s[7:0] > 8'd9)) begin
      r[0] = 4'd1;
      r[1] = 4'(s[7:0] - 8'd10);
    end else begin
      r[0] = 4'd0;
      r[1] = s[3:0];
    end
    return r;
  endfunction

  // Byte of the report 'X' hhmmss 'Y' CR LF at a given position.
  function automatic logic [7:0] report_byte(input digits_t d, input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] k;
    logic [7:0]       b;
    k = idx - IDX_W'(1);
    if (idx == IDX_W'(0)) b = CH_X;
    else if (idx <= IDX_W'(NUM_DIGITS)) b = CH_ZERO | {4'h0, d[k[DIG_W-1:0]]};
    else if (idx == IDX_W'(NUM_DIGITS + 1)) b = CH_Y;
    else if (idx == IDX_W'(NUM_DIGITS + 2)) b = CH_CR;
    else b = CH_LF;
    return b;
  endfunction

endpackage

// ===== rtl/core/nrtp_front.sv =====
// Sentence parser: header match, time capture, checksum and configuration registers.
module nrtp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  input  logic                          cfg_valid,
  input  logic [nrtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nrtp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  nrtp_pkg::qstatus_t            qstat,
  output nrtp_pkg::report_t             push
);

  nrtp_pkg::step_t   step, step_next;
  logic [nrtp_pkg::FCOUNT_W-1:0] fcount, fcount_next;
  logic [7:0]        run_xor, run_xor_next;
  logic [7:0]        cap_xor, cap_xor_next;
  logic [3:0]        high_nib, high_nib_next;
  nrtp_pkg::digits_t digits, digits_next;
  logic [7:0]        talker;
  logic [3:0]        offset;
  logic              accept;

  // Only the final checksum digit can produce a report, so only it waits for queue room.
  assign in_ready = (step != nrtp_pkg::ST_LOW_HEX) || !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    step_next     = step;
    fcount_next   = fcount;
    run_xor_next  = run_xor;
    cap_xor_next  = cap_xor;
    high_nib_next = high_nib;
    digits_next   = digits;
    push.valid    = 1'b0;
    push.digits   = digits;
    if (accept) begin
      if (rx_byte != nrtp_pkg::CH_STAR) run_xor_next = run_xor ^ rx_byte;
      unique case (step) inside
        nrtp_pkg::ST_HDR_G: begin
          step_next = (rx_byte == nrtp_pkg::CH_G) ? nrtp_pkg::ST_HDR_TALK : nrtp_pkg::ST_IDLE;
        end
        nrtp_pkg::ST_HDR_TALK: begin
          step_next = (rx_byte == talker) ? nrtp_pkg::ST_HDR_R : nrtp_pkg::ST_IDLE;
        end
        nrtp_pkg::ST_HDR_R: begin
          step_next = (rx_byte == nrtp_pkg::CH_R) ? nrtp_pkg::ST_HDR_M : nrtp_pkg::ST_IDLE;
        end
        nrtp_pkg::ST_HDR_M: begin
          step_next = (rx_byte == nrtp_pkg::CH_M) ? nrtp_pkg::ST_HDR_C : nrtp_pkg::ST_IDLE;
        end
        nrtp_pkg::ST_HDR_C: begin
          step_next = (rx_byte == nrtp_pkg::CH_C) ? nrtp_pkg::ST_HDR_COMMA : nrtp_pkg::ST_IDLE;
        end
        nrtp_pkg::ST_HDR_COMMA: begin
          fcount_next = '0;
          step_next = (rx_byte == nrtp_pkg::CH_COMMA) ? nrtp_pkg::ST_TIME : nrtp_pkg::ST_IDLE;
        end
        nrtp_pkg::ST_TIME: begin
          if (rx_byte == nrtp_pkg::CH_COMMA) begin
            if (fcount > nrtp_pkg::FCOUNT_W'(7)) begin
              digits_next = nrtp_pkg::convert_hour(digits, offset);
            end
            fcount_next = '0;
            step_next   = nrtp_pkg::ST_VALID;
          end else if (fcount < nrtp_pkg::FCOUNT_W'(nrtp_pkg::FIELD_LIMIT)) begin
            if (fcount < nrtp_pkg::FCOUNT_W'(nrtp_pkg::NUM_DIGITS)) begin
              digits_next[fcount[nrtp_pkg::DIG_W-1:0]] = rx_byte[3:0];
            end
            fcount_next = fcount + nrtp_pkg::FCOUNT_W'(1);
          end
        end
        nrtp_pkg::ST_VALID, nrtp_pkg::ST_WAIT_STAR: begin
          step_next = nrtp_pkg::ST_WAIT_STAR;
          if (rx_byte == nrtp_pkg::CH_STAR) begin
            cap_xor_next = run_xor;
            step_next    = nrtp_pkg::ST_HIGH_HEX;
          end
        end
        nrtp_pkg::ST_HIGH_HEX: begin
          high_nib_next = nrtp_pkg::hex_nibble(rx_byte);
          step_next     = nrtp_pkg::ST_LOW_HEX;
        end
        nrtp_pkg::ST_LOW_HEX: begin
          push.valid  = ({high_nib, nrtp_pkg::hex_nibble(rx_byte)} == cap_xor);
          digits_next = '0;
          step_next   = nrtp_pkg::ST_IDLE;
        end
        default: begin
          step_next    = (rx_byte == nrtp_pkg::CH_DOLLAR) ? nrtp_pkg::ST_HDR_G : nrtp_pkg::ST_IDLE;
          run_xor_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= nrtp_pkg::ST_IDLE;
      fcount   <= '0;
      run_xor  <= '0;
      cap_xor  <= '0;
      high_nib <= '0;
      digits   <= '0;
      talker   <= nrtp_pkg::TALKER_RESET;
      offset   <= '0;
    end else begin
      step     <= step_next;
      fcount   <= fcount_next;
      run_xor  <= run_xor_next;
      cap_xor  <= cap_xor_next;
      high_nib <= high_nib_next;
      digits   <= digits_next;
      if (cfg_valid && (cfg_index == nrtp_pkg::CFG_TALKER)) talker <= cfg_data[7:0];
      if (cfg_valid && (cfg_index == nrtp_pkg::CFG_OFFSET)) offset <= cfg_data[3:0];
    end
  end

endmodule

// ===== rtl/core/nrtp_queue.sv =====
// Short report queue between the parser and the report serialiser.
module nrtp_queue (
  input  logic               clk,
  input  logic               rst,
  input  nrtp_pkg::report_t  push,
  input  logic               pop,
  output nrtp_pkg::digits_t  head,
  output nrtp_pkg::qstatus_t status
);

  nrtp_pkg::digits_t              mem [nrtp_pkg::QUEUE_DEPTH];
  logic [nrtp_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [nrtp_pkg::QCOUNT_W-1:0]  count;

  assign status.full  = (count == nrtp_pkg::QCOUNT_W'(nrtp_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.digits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + nrtp_pkg::QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + nrtp_pkg::QPTR_W'(1);
      if (push.valid && !pop) count <= count + nrtp_pkg::QCOUNT_W'(1);
      else if (pop && !push.valid) count <= count - nrtp_pkg::QCOUNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/nrtp_back.sv =====
// Report serialiser: turns the queue head into ten output beats.
module nrtp_back (
  input  logic               clk,
  input  logic               rst,
  input  nrtp_pkg::digits_t  head,
  input  nrtp_pkg::qstatus_t qstat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               last_byte
);

  logic [nrtp_pkg::IDX_W-1:0] idx;
  logic                       beat;

  assign out_valid = !qstat.empty;
  assign beat      = out_valid && out_ready;
  assign last_byte = (idx == nrtp_pkg::IDX_W'(nrtp_pkg::REPORT_LEN - 1));
  assign out_byte  = nrtp_pkg::report_byte(head, idx);
  assign pop       = beat && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (beat) begin
      idx <= last_byte ? '0 : idx + nrtp_pkg::IDX_W'(1);
    end
  end

endmodule

// ===== rtl/core/nmea_rmc_time_parser_unit.sv =====
// A matching report is queued when its low checksum digit is taken, then offered in turn.
// Throughput: one byte in per cycle; a report's ten beats go one per out_ready cycle.
// The input stalls only on a low checksum digit while both report queue slots are occupied.
// Reset (synchronous, active high) returns the parser to idle, empties the queue,
// clears the time digits and sets the talker letter to 'P' and the hour offset to zero.
module nmea_rmc_time_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          last_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nrtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nrtp_pkg::CFG_DATA_W-1:0] cfg_data
);

  nrtp_pkg::report_t  push;
  nrtp_pkg::qstatus_t qstat;
  nrtp_pkg::digits_t  head;
  logic               pop;

  // Configuration registers live in the parser and take a write in any cycle.
  assign cfg_ready = 1'b1;

  // The front end walks the sentence one beat at a time and, when the checksum
  // agrees, hands the six time digits over as one report.
  nrtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push)
  );

  // Two report slots decouple parsing from a slow consumer.
  nrtp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (qstat)
  );

  // The back end formats the head report and frees its slot on the line feed beat.
  nrtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule

// ===== rtl/core/nrtp_checker.sv =====
// Port-level checks of the RMC time parser and their binding to the top level.
module nrtp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [7:0]                    out_byte,
  input logic                          last_byte
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat offered straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(last_byte)))
    else $error("stalled output beat changed");

  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte) |-> (out_byte == nrtp_pkg::CH_LF))
    else $error("final beat of a report is not a line feed");

  a_lf_follows_cr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && (out_byte == nrtp_pkg::CH_CR) && !last_byte)
      |=> (out_valid && last_byte))
    else $error("carriage return not followed by the final line feed");

endmodule

bind nmea_rmc_time_parser_unit nrtp_checker u_nrtp_checker (.*);

// ===== tb/nmea_rmc_time_parser_unit_tb.sv =====
// Self-checking testbench for the RMC sentence time parser, with its own parse model.
`timescale 1ns / 1ps

module nmea_rmc_time_parser_unit_tb;
  import nrtp_pkg::*;

  // One beat of the time report as it should leave the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } report_beat_t;

  // A run is ended when this many cycles pass without any beat moving on any channel.
  localparam int STALL_LIMIT  = 2000;
  // Cycles allowed after the last expected beat for anything still in flight to show.
  localparam int SETTLE_TICKS = 16;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [7:0]            rx_byte   = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_byte;
  logic                  last_byte;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  nmea_rmc_time_parser_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Parser model state and its copy of the two registers, all at their reset values.
  logic [7:0]   want_talker  = TALKER_RESET;
  logic [3:0]   local_offset = 4'd0;
  step_t        prs_step     = ST_IDLE;
  int           time_count   = 0;
  logic [7:0]   sum_run      = 8'h00;
  logic [7:0]   sum_held     = 8'h00;
  logic [3:0]   hi_nib       = 4'h0;
  logic [3:0]   clock_digits [NUM_DIGITS] = '{default: 4'h0};

  // Bytes waiting to be offered, and report beats still owed by the block.
  logic [7:0]   byte_q [$];
  report_beat_t due_report_q [$];
  report_beat_t due_beat;

  int queued_total = 0;
  int bytes_taken  = 0;
  int errors       = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int quiet_cycles = 0;
  bit gaps_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Value of a checksum character: anything above '9' is moved down so that 'A' gives ten,
  // and only the low nibble survives, so every byte maps onto some nibble.
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = (c > CH_NINE) ? (c - HEX_ALPHA_ADJ) : c;
    return v[3:0];
  endfunction

  // Character that encodes a nibble: the usual upper-case digit, or when odd is set any
  // byte at all that happens to decode to the same nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit odd);
    logic [7:0] c;
    if (odd) begin
      do c = 8'($urandom_range(0, 255)); while (digit_value(c) != n);
    end else begin
      c = (n < 4'd10) ? (CH_ZERO + 8'(n)) : (HEX_ALPHA_ADJ + 8'(n));
    end
    return c;
  endfunction

  // Turns the captured UTC hour into the local 12-hour form. The arithmetic is unsigned
  // on purpose: an offset more than twelve above the hour wraps to a huge value, which then counts
  // as above nine, so the tens digit becomes one and the ones digit keeps a low nibble.
  task automatic shift_hour();
    int unsigned h;
    h = int'(clock_digits[0]) * 10 + int'(clock_digits[1]);
    if (h > 12) h = h - 12;
    if (h <= local_offset) h = h + 12;
    h = h - local_offset;
    if (h > 9) begin
      clock_digits[0] = 4'd1;
      h = h - 10;
    end else begin
      clock_digits[0] = 4'd0;
    end
    clock_digits[1] = h[3:0];
  endtask

  task automatic header_step(input logic [7:0] c, input logic [7:0] want, input step_t nxt);
    prs_step = (c == want) ? nxt : ST_IDLE;
  endtask

  // Advances the parse model by one accepted byte and queues any report that it completes.
  task automatic track_sentence_byte(input logic [7:0] c);
    logic [7:0] rx_sum;
    if (c != CH_STAR) sum_run = sum_run ^ c;
    case (prs_step)
      ST_HDR_G:    header_step(c, CH_G, ST_HDR_TALK);
      ST_HDR_TALK: header_step(c, want_talker, ST_HDR_R);
      ST_HDR_R:    header_step(c, CH_R, ST_HDR_M);
      ST_HDR_M:    header_step(c, CH_M, ST_HDR_C);
      ST_HDR_C:    header_step(c, CH_C, ST_HDR_COMMA);
      ST_HDR_COMMA: begin
        time_count = 0;
        header_step(c, CH_COMMA, ST_TIME);
      end
      ST_TIME: begin
        if (c == CH_COMMA) begin
          // Only a time field longer than seven characters, as with fractional seconds, is shown as local time.
          if (time_count > 7) shift_hour();
          time_count = 0;
          prs_step = ST_VALID;
        end else if (time_count < FIELD_LIMIT) begin
          if (time_count < NUM_DIGITS) clock_digits[time_count] = c[3:0];
          time_count++;
        end
      end
      // The validity byte is never looked at, so a star there captures the sum at once.
      ST_VALID, ST_WAIT_STAR: begin
        prs_step = ST_WAIT_STAR;
        if (c == CH_STAR) begin
          sum_held = sum_run;
          prs_step = ST_HIGH_HEX;
        end
      end
      ST_HIGH_HEX: begin
        hi_nib = digit_value(c);
        prs_step = ST_LOW_HEX;
      end
      ST_LOW_HEX: begin
        rx_sum = {hi_nib, digit_value(c)};
        if (rx_sum == sum_held) begin
          due_report_q.push_back('{ch: CH_X, fin: 1'b0});
          for (int i = 0; i < NUM_DIGITS; i++)
            due_report_q.push_back('{ch: CH_ZERO | {4'h0, clock_digits[i]}, fin: 1'b0});
          due_report_q.push_back('{ch: CH_Y, fin: 1'b0});
          due_report_q.push_back('{ch: CH_CR, fin: 1'b0});
          due_report_q.push_back('{ch: CH_LF, fin: 1'b1});
        end
        // The digits are cleared whether or not the checksum matched.
        for (int i = 0; i < NUM_DIGITS; i++) clock_digits[i] = 4'h0;
        prs_step = ST_IDLE;
      end
      default: begin
        prs_step = (c == CH_DOLLAR) ? ST_HDR_G : ST_IDLE;
        sum_run = 8'h00;
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_q.push_back(b);
    queued_total++;
  endtask

  // Queues one RMC sentence. The time field is taken from tm, or made up at random when
  // rand_len is not negative. break_at names a header position to spoil (zero for none).
  // A star in the validity position ends the sentence there, as the parser allows.
  task automatic add_sentence(input string tm, input int rand_len, input int rest_len,
                              input bit bad_sum, input int break_at, input bit star_valid,
                              input bit odd_hex);
    logic [7:0] s [$];
    logic [7:0] c;
    logic [7:0] sum;
    int         n;
    s = '{CH_DOLLAR, CH_G, want_talker, CH_R, CH_M, CH_C, CH_COMMA};
    if (break_at > 0) begin
      c = s[break_at];
      do s[break_at] = 8'($urandom_range(0, 255)); while (s[break_at] == c);
    end
    n = (rand_len < 0) ? tm.len() : rand_len;
    for (int i = 0; i < n; i++) begin
      if (rand_len < 0) begin
        c = tm[i];
      end else if ($urandom_range(0, 4) != 0) begin
        c = CH_ZERO + 8'($urandom_range(0, 9));
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA);
      end
      s.push_back(c);
    end
    s.push_back(CH_COMMA);
    if (!star_valid) begin
      s.push_back(($urandom_range(0, 1) != 0) ? "A" : "V");
      for (int i = 0; i < rest_len; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_STAR);
        s.push_back(c);
      end
    end
    s.push_back(CH_STAR);
    // Standard NMEA sum: every byte after the dollar, stars left out.
    sum = 8'h00;
    for (int i = 1; i < s.size(); i++)
      if (s[i] != CH_STAR) sum = sum ^ s[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    s.push_back(hex_char(sum[7:4], odd_hex));
    s.push_back(hex_char(sum[3:0], odd_hex));
    foreach (s[i]) queue_byte(s[i]);
  endtask

  // Mostly well-formed sentences with random content, with some line noise, broken
  // headers and bad sums mixed in. Time fields favour six characters and the long form
  // that triggers the local-hour conversion.
  task automatic fill_random(input int budget);
    int start;
    int tl;
    int pick;
    start = queued_total;
    while (queued_total - start < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) tl = NUM_DIGITS;
        else if (pick < 8) tl = $urandom_range(8, 10);
        else tl = $urandom_range(0, 20);
        add_sentence("", tl, $urandom_range(0, 5), $urandom_range(0, 9) == 0,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0,
                     $urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0);
      end
    end
  endtask

  // Register writes go out one beat at a time; the model takes the value on the same
  // edge as the block does.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TALKER) want_talker = val;
    else if (idx == CFG_OFFSET) local_offset = val[3:0];
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued byte has been taken and every owed beat has come out, then
  // leaves a few more cycles so that a stray report would still be seen.
  task automatic wait_drained();
    do @(posedge clk); while (bytes_taken != queued_total || due_report_q.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Byte driver. A new byte is put up only once the previous one has been taken, and an
  // idle burst is thrown in now and then while gaps are enabled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        track_sentence_byte(rx_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0 && gaps_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte  <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor. Every beat taken is compared with the oldest one owed; back-pressure
  // comes in bursts while gaps are enabled, so that stalls land inside reports too.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_report_q.size() == 0) begin
          $error("out_byte: expected none, got %h", out_byte);
          errors++;
        end else begin
          due_beat = due_report_q.pop_front();
          if (out_byte !== due_beat.ch) begin
            $error("out_byte: expected %h, got %h", due_beat.ch, out_byte);
            errors++;
          end
          if (last_byte !== due_beat.fin) begin
            $error("last_byte: expected %b, got %b", due_beat.fin, last_byte);
            errors++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that stops moving beats on every channel for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset register values, written explicitly, with the basic sentence shapes.
    cfg_write(CFG_TALKER, "P");
    cfg_write(CFG_OFFSET, 8'd0);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    add_sentence("123456", -1, 0, 1'b0, 0, 1'b0, 1'b0);
    add_sentence("235959.00", -1, 2, 1'b0, 0, 1'b0, 1'b0);
    // Talker letter spoilt: the sentence is dropped and the digits are left alone.
    add_sentence("101010", -1, 0, 1'b0, 2, 1'b0, 1'b0);
    // Short time field with the star straight after it, in the validity position.
    add_sentence("0815", -1, 0, 1'b0, 0, 1'b1, 1'b0);
    add_sentence("999999", -1, 0, 1'b1, 0, 1'b0, 1'b0);
    // Time field far longer than the parser counts.
    add_sentence("12345678901234567890", -1, 0, 1'b0, 0, 1'b0, 1'b0);
    // Empty time field, checksum written with odd characters that still decode right.
    add_sentence("", -1, 0, 1'b0, 0, 1'b0, 1'b1);
    fill_random(8);
    wait_drained();

    // GN talker at an offset of twelve: midnight and noon sit on the edges of the shift.
    cfg_write(CFG_TALKER, "N");
    cfg_write(CFG_OFFSET, 8'd12);
    add_sentence("000000.0", -1, 0, 1'b0, 0, 1'b0, 1'b0);
    add_sentence("120000.00", -1, 0, 1'b0, 0, 1'b0, 1'b0);
    add_sentence("130000.00", -1, 1, 1'b0, 0, 1'b0, 1'b0);
    fill_random(8);
    wait_drained();

    // An offset beyond twelve makes the hour wrap; non-digit time characters give
    // nibbles above nine, which the conversion takes without any range check.
    cfg_write(CFG_TALKER, 8'hFF);
    cfg_write(CFG_OFFSET, 8'd15);
    add_sentence("010000.00", -1, 0, 1'b0, 0, 1'b0, 1'b0);
    add_sentence("??????.??", -1, 0, 1'b0, 0, 1'b0, 1'b0);
    fill_random(8);
    wait_drained();

    cfg_write(CFG_TALKER, 8'h00);
    cfg_write(CFG_OFFSET, 8'($urandom_range(0, 12)));
    fill_random(8);
    wait_drained();

    // Closing stretch at full rate, with no idling on either side.
    gaps_on = 1'b0;
    cfg_write(CFG_TALKER, 8'($urandom_range(0, 255)));
    cfg_write(CFG_OFFSET, 8'($urandom_range(0, 12)));
    fill_random(16);
    wait_drained();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/nrtp_pkg.sv
rtl/core/nrtp_front.sv
rtl/core/nrtp_queue.sv
rtl/core/nrtp_back.sv
rtl/core/nmea_rmc_time_parser_unit.sv
rtl/core/nrtp_checker.sv
tb/nmea_rmc_time_parser_unit_tb.sv
